/* rtl/cpmt_pkg.sv */
// Shared constants, types and helper functions of the convex polygon triangulation block.
`default_nettype none
package cpmt_pkg;
	localparam int MAX_VERTICES = 32;
	localparam int FRAC_BITS = 8;
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = IDX_W + 1;
	localparam int COORD_W = 16;
	localparam int CHORD_W = 26;
	localparam int COST_W = 32;
	localparam int END_W = 6;
	localparam int SPLIT_W = 6;
	localparam int MAX_DIAG = MAX_VERTICES - 3;
	localparam int STACK_DEPTH = 2 * MAX_VERTICES;
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int SP_W = STK_AW + 1;
	localparam int SQ_W = 2 * COORD_W + 2;
	localparam int ROOT_STEPS = SQ_W / 2 + FRAC_BITS;
	localparam int SH_W = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = ROOT_STEPS;
	localparam int REM_W = ROOT_W + 1;
	localparam int STEP_W = $clog2(ROOT_STEPS);

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_NONE,
		OP_CH_SQ,
		OP_CH_RT,
		OP_CH_WR,
		OP_DI,
		OP_DP_ST,
		OP_DP_AC,
		OP_DP_WR,
		OP_PK_AC,
		OP_TOP,
		OP_TOP2,
		OP_POP,
		OP_CHK,
		OP_SPL,
		OP_PSH2,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic few;
		logic root_last;
		logic ch_last;
		logic i_last;
		logic k_end;
		logic dp_last;
		logic pk_last;
		logic top_go;
		logic skip;
		logic chk_go;
		logic stk_empty;
		logic fin_go;
		logic none_go;
	} stat_t;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             emit;
	} stk_entry_t;

	// (x + 1) mod n for x below n
	function automatic logic [IDX_W-1:0] inc_mod(input logic [IDX_W-1:0] x,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] s;
		s = {1'b0, x} + CNT_W'(1);
		return (s == n) ? '0 : s[IDX_W-1:0];
	endfunction

	// (x + d) mod n for x below n and d below n
	function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] x,
		input logic [CNT_W-1:0] d, input logic [CNT_W-1:0] n);
		logic [CNT_W:0] s;
		logic [CNT_W:0] r;
		s = {2'b00, x} + {1'b0, d};
		r = (s >= {1'b0, n}) ? (s - {1'b0, n}) : s;
		return r[IDX_W-1:0];
	endfunction
endpackage
`default_nettype wire

/* rtl/cpmt_vtx_if.sv */
// Vertex input channel: valid/ready handshake with coordinate payload.
`default_nettype none
interface cpmt_vtx_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_coord;
	logic signed [15:0] y_coord;
	logic               last_vertex;

	modport source (output valid, output x_coord, output y_coord, output last_vertex,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input last_vertex,
		output ready);
endinterface
`default_nettype wire

/* rtl/cpmt_diag_if.sv */
// Diagonal result channel: valid/ready handshake with vertex pair payload.
`default_nettype none
interface cpmt_diag_if;
	logic       valid;
	logic       ready;
	logic [5:0] end_a;
	logic [5:0] end_b;
	logic       no_diagonal;
	logic       last_result;

	modport source (output valid, output end_a, output end_b, output no_diagonal,
		output last_result, input ready);
	modport sink (input valid, input end_a, input end_b, input no_diagonal,
		input last_result, output ready);
endinterface
`default_nettype wire

/* rtl/convex_polygon_min_triangulation.sv */
// Minimum-weight triangulation of a convex polygon: top level.
// Usage:
//   vtx carries one vertex per transfer (x_coord, y_coord, last_vertex). Vertices
//   are taken one per cycle while the block is loading; up to 32 are kept and
//   later ones are dropped. The transfer with last_vertex set starts the solve.
//   diag returns the diagonals as 1-based vertex pairs, last_result on the last
//   one; a polygon of fewer than four vertices yields one result with
//   no_diagonal set.
// Phases for n vertices:
//   chord table: n*n pairs, each computed by the one-digit-per-cycle square
//   root unit; interval fill: a read and accumulate per split candidate;
//   pair search: n*n pairs; split walk: pop, check, split read, two pushes.
//   vtx.ready is low from the last vertex until the final diagonal has left the
//   pending slot, so one polygon is processed at a time.
// Reset clears the controller, counters and output valid; tables need no clearing.
// When diag stalls the result is held in the output register and the walk waits.
`default_nettype none
module convex_polygon_min_triangulation
	import cpmt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	cpmt_vtx_if.sink    vtx,
	cpmt_diag_if.source diag
);
	cmd_t  cmd;
	stat_t stat;

	cpmt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	cpmt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.vtx    (vtx),
		.diag   (diag)
	);
endmodule
`default_nettype wire

/* rtl/cpmt_dp.sv */
// Datapath: vertex store, chord root unit, cost tables, split walk stack and output register.
`default_nettype none
module cpmt_dp
	import cpmt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cmd_t   cmd,
	output stat_t       stat,
	cpmt_vtx_if.sink    vtx,
	cpmt_diag_if.source diag
);
	logic signed [COORD_W-1:0] vx_mem [MAX_VERTICES];
	logic signed [COORD_W-1:0] vy_mem [MAX_VERTICES];
	logic [CHORD_W-1:0]        chord_mem [MAX_VERTICES*MAX_VERTICES];
	logic [COST_W-1:0]         cost_mem [MAX_VERTICES*MAX_VERTICES];
	logic [SPLIT_W-1:0]        split_mem [MAX_VERTICES*MAX_VERTICES];
	stk_entry_t                stk_mem [STACK_DEPTH];

	logic signed [COORD_W-1:0] xi_q, xj_q, yi_q, yj_q;
	logic [CHORD_W-1:0]        chord_rd_q;
	logic [COST_W-1:0]         cost_a_q, cost_b_q;
	logic [SPLIT_W-1:0]        split_rd_q;
	stk_entry_t                stk_rd_q;

	logic [CNT_W-1:0]  cnt_q, n_q, len_q;
	logic [IDX_W-1:0]  i_q, j_q, k_q, bestk_q, bi_q, bj_q, wa_q, wb_q;
	logic              got_q, have_q, pick_q;
	logic [COST_W-1:0] best_q;
	logic [COST_W:0]   pbest_q;
	logic [SP_W-1:0]   sp_q;
	logic [END_W-1:0]  dcnt_q;
	logic              pend_valid_q;
	logic [IDX_W-1:0]  pend_a_q, pend_b_q;
	logic              out_valid_q, out_none_q, out_last_q;
	logic [END_W-1:0]  out_a_q, out_b_q;
	logic [SH_W-1:0]   s_sh_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;

	logic                      accept;
	logic [CNT_W-1:0]          cnt_next;
	logic [CNT_W-1:0]          n_m1;
	logic                      i_end, j_end;
	logic [2*IDX_W-1:0]        addr_ij, addr_a, addr_b, cost_wa;
	logic                      cost_we;
	logic [COST_W-1:0]         cost_wd;
	logic signed [COORD_W:0]   dx, dy;
	logic [COORD_W:0]          mx, my;
	logic [2*COORD_W-1:0]      sqx, sqy;
	logic [SQ_W-1:0]           ssum;
	logic [REM_W+1:0]          rem_n, trial;
	logic [CHORD_W-1:0]        chord_val;
	logic                      zero_chord;
	logic [COST_W-1:0]         dp_c;
	logic [COST_W:0]           pk_t;
	logic                      top_nonadj, out_free, can_emit;
	stk_entry_t                ent;
	logic                      ent_skip, ent_want;
	logic                      emit_fire, send;
	logic [IDX_W-1:0]          emit_a, emit_b;
	logic                      stk_we;
	stk_entry_t                stk_wd;
	logic                      sp_ok;

	assign vtx.ready = (cmd.op == OP_LOAD);
	assign accept = vtx.valid && vtx.ready;
	assign cnt_next = (cnt_q < CNT_W'(MAX_VERTICES)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign n_m1 = n_q - CNT_W'(1);
	assign i_end = ({1'b0, i_q} == n_m1);
	assign j_end = ({1'b0, j_q} == n_m1);

	assign addr_ij = {i_q, j_q};
	assign addr_a = pick_q ? {i_q, j_q} : {i_q, k_q};
	assign addr_b = pick_q ? {j_q, i_q} : {k_q, j_q};

	// Vertex store
	always_ff @(posedge clk) begin
		if (accept && cnt_q < CNT_W'(MAX_VERTICES)) begin
			vx_mem[cnt_q[IDX_W-1:0]] <= vtx.x_coord;
			vy_mem[cnt_q[IDX_W-1:0]] <= vtx.y_coord;
		end
		xi_q <= vx_mem[i_q];
		xj_q <= vx_mem[j_q];
		yi_q <= vy_mem[i_q];
		yj_q <= vy_mem[j_q];
	end

	// Squared distance
	assign dx = {xi_q[COORD_W-1], xi_q} - {xj_q[COORD_W-1], xj_q};
	assign dy = {yi_q[COORD_W-1], yi_q} - {yj_q[COORD_W-1], yj_q};
	assign mx = dx[COORD_W] ? (~dx + 1'b1) : dx;
	assign my = dy[COORD_W] ? (~dy + 1'b1) : dy;
	assign sqx = mx[COORD_W-1:0] * mx[COORD_W-1:0];
	assign sqy = my[COORD_W-1:0] * my[COORD_W-1:0];
	assign ssum = SQ_W'(sqx) + SQ_W'(sqy);

	// One root digit per step
	assign rem_n = {rem_q, s_sh_q[SH_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign zero_chord = (i_q == j_q) || (inc_mod(i_q, n_q) == j_q) || (inc_mod(j_q, n_q) == i_q);
	assign chord_val = zero_chord ? '0 :
		(CHORD_W'(root_q) + CHORD_W'(rem_q > {1'b0, root_q}));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CH_SQ) begin
			s_sh_q <= {ssum, {(2*FRAC_BITS){1'b0}}};
			root_q <= '0;
			rem_q <= '0;
			step_q <= '0;
		end else if (cmd.op == OP_CH_RT) begin
			s_sh_q <= {s_sh_q[SH_W-3:0], 2'b00};
			step_q <= step_q + STEP_W'(1);
			if (rem_n >= trial) begin
				rem_q <= REM_W'(rem_n - trial);
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= REM_W'(rem_n);
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Chord, cost and split tables
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CH_WR)
			chord_mem[addr_ij] <= chord_val;
		chord_rd_q <= chord_mem[addr_ij];
	end

	assign cost_we = (cmd.op == OP_DI) || (cmd.op == OP_DP_WR);
	assign cost_wa = (cmd.op == OP_DI) ? {i_q, inc_mod(i_q, n_q)} : addr_ij;
	assign cost_wd = (cmd.op == OP_DI) ? '0 : best_q;

	always_ff @(posedge clk) begin
		if (cost_we)
			cost_mem[cost_wa] <= cost_wd;
		cost_a_q <= cost_mem[addr_a];
		cost_b_q <= cost_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DP_WR)
			split_mem[addr_ij] <= SPLIT_W'(bestk_q);
		split_rd_q <= split_mem[{wa_q, wb_q}];
	end

	assign dp_c = COST_W'(chord_rd_q) + cost_a_q + cost_b_q;
	assign pk_t = {1'b0, cost_a_q} + {1'b0, cost_b_q} - (COST_W+1)'(chord_rd_q);

	// Walk stack
	assign ent = stk_rd_q;
	assign ent_skip = ({1'b0, ent.a} >= n_q) || ({1'b0, ent.b} >= n_q) || (ent.a == ent.b) ||
		(inc_mod(ent.a, n_q) == ent.b);
	assign ent_want = ent.emit && (dcnt_q < END_W'(MAX_DIAG));
	assign top_nonadj = (inc_mod(bj_q, n_q) != bi_q) && (inc_mod(bi_q, n_q) != bj_q);
	assign out_free = !out_valid_q || diag.ready;
	assign can_emit = !pend_valid_q || out_free;
	assign sp_ok = (sp_q < SP_W'(STACK_DEPTH));

	always_comb begin
		stk_we = 1'b0;
		stk_wd = '0;
		case (cmd.op)
			OP_TOP: begin
				stk_we = !top_nonadj || can_emit;
				stk_wd = '{a: bj_q, b: bi_q, emit: 1'b0};
			end
			OP_TOP2: begin
				stk_we = 1'b1;
				stk_wd = '{a: bi_q, b: bj_q, emit: 1'b0};
			end
			OP_SPL: begin
				stk_we = 1'b1;
				stk_wd = '{a: split_rd_q[IDX_W-1:0], b: wb_q, emit: 1'b1};
			end
			OP_PSH2: begin
				stk_we = 1'b1;
				stk_wd = '{a: wa_q, b: split_rd_q[IDX_W-1:0], emit: 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we && sp_ok)
			stk_mem[sp_q[STK_AW-1:0]] <= stk_wd;
		if (cmd.op == OP_POP)
			stk_rd_q <= stk_mem[STK_AW'(sp_q - SP_W'(1))];
	end

	// Emission into the pending slot
	always_comb begin
		emit_fire = 1'b0;
		emit_a = bi_q;
		emit_b = bj_q;
		if (cmd.op == OP_TOP)
			emit_fire = top_nonadj && can_emit;
		else if (cmd.op == OP_CHK) begin
			emit_fire = !ent_skip && ent_want && can_emit;
			emit_a = ent.a;
			emit_b = ent.b;
		end
	end

	assign send = (emit_fire && pend_valid_q) ||
		(cmd.op == OP_FIN && pend_valid_q && out_free) ||
		(cmd.op == OP_NONE && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (send)
				out_valid_q <= 1'b1;
			else if (diag.ready)
				out_valid_q <= 1'b0;
			if (emit_fire)
				pend_valid_q <= 1'b1;
			else if (cmd.op == OP_FIN && out_free)
				pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			pend_a_q <= emit_a;
			pend_b_q <= emit_b;
		end
		if (send) begin
			if (cmd.op == OP_NONE) begin
				out_a_q <= '0;
				out_b_q <= '0;
				out_none_q <= 1'b1;
				out_last_q <= 1'b1;
			end else begin
				out_a_q <= END_W'(pend_a_q) + END_W'(1);
				out_b_q <= END_W'(pend_b_q) + END_W'(1);
				out_none_q <= 1'b0;
				out_last_q <= (cmd.op == OP_FIN);
			end
		end
	end

	assign diag.valid = out_valid_q;
	assign diag.end_a = out_a_q;
	assign diag.end_b = out_b_q;
	assign diag.no_diagonal = out_none_q;
	assign diag.last_result = out_last_q;

	// Loop counters and running minima
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			len_q <= '0;
			got_q <= 1'b0;
			have_q <= 1'b0;
			pick_q <= 1'b0;
			sp_q <= '0;
			dcnt_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_LOAD: begin
					if (accept) begin
						if (vtx.last_vertex) begin
							n_q <= cnt_next;
							cnt_q <= '0;
							i_q <= '0;
							j_q <= '0;
							pick_q <= 1'b0;
							sp_q <= '0;
							dcnt_q <= '0;
						end else
							cnt_q <= cnt_next;
					end
				end
				OP_CH_WR, OP_PK_AC: begin
					if (j_end) begin
						j_q <= '0;
						i_q <= i_end ? '0 : i_q + IDX_W'(1);
					end else
						j_q <= j_q + IDX_W'(1);
					if (cmd.op == OP_PK_AC && i_q != j_q && (!have_q || pk_t < pbest_q)) begin
						have_q <= 1'b1;
					end
				end
				OP_DI: begin
					if (i_end) begin
						i_q <= '0;
						len_q <= CNT_W'(2);
					end else
						i_q <= i_q + IDX_W'(1);
				end
				OP_DP_ST: begin
					j_q <= add_mod(i_q, len_q, n_q);
					k_q <= inc_mod(i_q, n_q);
					got_q <= 1'b0;
				end
				OP_DP_AC: begin
					k_q <= inc_mod(k_q, n_q);
					got_q <= 1'b1;
				end
				OP_DP_WR: begin
					if (i_end) begin
						i_q <= '0;
						len_q <= len_q + CNT_W'(1);
					end else
						i_q <= i_q + IDX_W'(1);
					if (i_end && len_q == n_m1) begin
						j_q <= '0;
						have_q <= 1'b0;
						pick_q <= 1'b1;
					end
				end
				OP_TOP: begin
					if (!top_nonadj || can_emit)
						sp_q <= SP_W'(1);
				end
				OP_TOP2, OP_SPL, OP_PSH2: begin
					if (sp_ok)
						sp_q <= sp_q + SP_W'(1);
				end
				OP_POP: sp_q <= sp_q - SP_W'(1);
				default: ;
			endcase
			if (emit_fire)
				dcnt_q <= dcnt_q + END_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_DP_AC && (!got_q || dp_c < best_q)) begin
			best_q <= dp_c;
			bestk_q <= k_q;
		end
		if (cmd.op == OP_PK_AC && i_q != j_q && (!have_q || pk_t < pbest_q)) begin
			pbest_q <= pk_t;
			bi_q <= i_q;
			bj_q <= j_q;
		end
		if (cmd.op == OP_CHK) begin
			wa_q <= ent.a;
			wb_q <= ent.b;
		end
	end

	assign stat.start = accept && vtx.last_vertex;
	assign stat.few = (cnt_next < CNT_W'(4));
	assign stat.root_last = (step_q == STEP_W'(ROOT_STEPS - 1));
	assign stat.ch_last = i_end && j_end;
	assign stat.i_last = i_end;
	assign stat.k_end = (inc_mod(k_q, n_q) == j_q);
	assign stat.dp_last = i_end && (len_q == n_m1);
	assign stat.pk_last = i_end && j_end;
	assign stat.top_go = !top_nonadj || can_emit;
	assign stat.skip = ent_skip;
	assign stat.chk_go = ent_skip || !ent_want || can_emit;
	assign stat.stk_empty = (sp_q == '0);
	assign stat.fin_go = !pend_valid_q || out_free;
	assign stat.none_go = out_free;
endmodule
`default_nettype wire

/* rtl/cpmt_ctrl.sv */
// Controller: sequences loading, chord table, interval fill, pair search and split walk.
`default_nettype none
module cpmt_ctrl
	import cpmt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output cmd_t       cmd
);
	typedef enum logic [20:0] {
		S_LOAD  = 21'd1 << 0,
		S_NONE  = 21'd1 << 1,
		S_CH_RD = 21'd1 << 2,
		S_CH_SQ = 21'd1 << 3,
		S_CH_RT = 21'd1 << 4,
		S_CH_WR = 21'd1 << 5,
		S_DI    = 21'd1 << 6,
		S_DP_ST = 21'd1 << 7,
		S_DP_RD = 21'd1 << 8,
		S_DP_AC = 21'd1 << 9,
		S_DP_WR = 21'd1 << 10,
		S_PK_RD = 21'd1 << 11,
		S_PK_AC = 21'd1 << 12,
		S_TOP   = 21'd1 << 13,
		S_TOP2  = 21'd1 << 14,
		S_POP   = 21'd1 << 15,
		S_CHK   = 21'd1 << 16,
		S_SPA   = 21'd1 << 17,
		S_SPL   = 21'd1 << 18,
		S_PSH2  = 21'd1 << 19,
		S_FIN   = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_LOAD;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NOP;
		unique case (state_q)
			S_LOAD: begin
				cmd.op = OP_LOAD;
				if (stat.start)
					state_d = stat.few ? S_NONE : S_CH_RD;
			end
			S_NONE: begin
				cmd.op = OP_NONE;
				if (stat.none_go)
					state_d = S_LOAD;
			end
			S_CH_RD: state_d = S_CH_SQ;
			S_CH_SQ: begin
				cmd.op = OP_CH_SQ;
				state_d = S_CH_RT;
			end
			S_CH_RT: begin
				cmd.op = OP_CH_RT;
				if (stat.root_last)
					state_d = S_CH_WR;
			end
			S_CH_WR: begin
				cmd.op = OP_CH_WR;
				state_d = stat.ch_last ? S_DI : S_CH_RD;
			end
			S_DI: begin
				cmd.op = OP_DI;
				if (stat.i_last)
					state_d = S_DP_ST;
			end
			S_DP_ST: begin
				cmd.op = OP_DP_ST;
				state_d = S_DP_RD;
			end
			S_DP_RD: state_d = S_DP_AC;
			S_DP_AC: begin
				cmd.op = OP_DP_AC;
				state_d = stat.k_end ? S_DP_WR : S_DP_RD;
			end
			S_DP_WR: begin
				cmd.op = OP_DP_WR;
				state_d = stat.dp_last ? S_PK_RD : S_DP_ST;
			end
			S_PK_RD: state_d = S_PK_AC;
			S_PK_AC: begin
				cmd.op = OP_PK_AC;
				state_d = stat.pk_last ? S_TOP : S_PK_RD;
			end
			S_TOP: begin
				cmd.op = OP_TOP;
				if (stat.top_go)
					state_d = S_TOP2;
			end
			S_TOP2: begin
				cmd.op = OP_TOP2;
				state_d = S_POP;
			end
			S_POP: begin
				cmd.op = OP_POP;
				state_d = S_CHK;
			end
			S_CHK: begin
				cmd.op = OP_CHK;
				if (stat.skip)
					state_d = stat.stk_empty ? S_FIN : S_POP;
				else if (stat.chk_go)
					state_d = S_SPA;
			end
			S_SPA: state_d = S_SPL;
			S_SPL: begin
				cmd.op = OP_SPL;
				state_d = S_PSH2;
			end
			S_PSH2: begin
				cmd.op = OP_PSH2;
				state_d = S_POP;
			end
			S_FIN: begin
				cmd.op = OP_FIN;
				if (stat.fin_go)
					state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end
endmodule
`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the convex polygon minimum-weight triangulation block.
`default_nettype none
class triangulation_scoreboard;
	typedef struct {
		logic [5:0] end_a;
		logic [5:0] end_b;
		logic       no_diagonal;
		logic       last_result;
	} diag_t;

	int          vert_x[cpmt_pkg::MAX_VERTICES];
	int          vert_y[cpmt_pkg::MAX_VERTICES];
	int          vert_count;
	diag_t       expected_diags[$];
	int          mismatches;

	function new();
		vert_count = 0;
		mismatches = 0;
	endfunction

	static function bit is_next(int i, int j, int n);
		return ((i + 1) % n) == j;
	endfunction

	// round(sqrt(s) * 2^FRAC_BITS), one result digit per iteration
	static function longint unsigned fixed_root(longint unsigned s);
		longint unsigned root, rem, trial;
		root = 0;
		rem = 0;
		for (int t = 16; t >= 0; t--) begin
			rem = (rem << 2) | ((s >> (2 * t)) & 3);
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else
				root = root << 1;
		end
		for (int t = 0; t < cpmt_pkg::FRAC_BITS; t++) begin
			rem = rem << 2;
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem -= trial;
				root = (root << 1) | 1;
			end else
				root = root << 1;
		end
		if (rem > root)
			root += 1;
		return root;
	endfunction

	function void add_diag(int a, int b, bit none);
		diag_t d;
		d.end_a = a[5:0];
		d.end_b = b[5:0];
		d.no_diagonal = none;
		d.last_result = 1'b0;
		expected_diags.push_back(d);
	endfunction

	function void triangulate();
		int n, j, bi, bj, a, b, k, emitted;
		longint unsigned chord[32][32];
		longint unsigned cost[32][32];
		int split[32][32];
		longint unsigned best, c, t, dx, dy;
		bit have, got;
		int stk_a[$], stk_b[$], stk_e[$];
		n = vert_count;
		vert_count = 0;
		emitted = 0;
		if (n < 4) begin
			add_diag(0, 0, 1'b1);
			expected_diags[$].last_result = 1'b1;
			return;
		end
		for (int i = 0; i < n; i++)
			for (int jj = 0; jj < n; jj++) begin
				if (i == jj || is_next(i, jj, n) || is_next(jj, i, n))
					chord[i][jj] = 0;
				else begin
					dx = (vert_x[i] > vert_x[jj]) ? vert_x[i] - vert_x[jj] : vert_x[jj] - vert_x[i];
					dy = (vert_y[i] > vert_y[jj]) ? vert_y[i] - vert_y[jj] : vert_y[jj] - vert_y[i];
					chord[i][jj] = fixed_root(dx * dx + dy * dy);
				end
			end
		for (int i = 0; i < n; i++) begin
			cost[i][(i + 1) % n] = 0;
			split[i][(i + 1) % n] = 0;
		end
		for (int len = 2; len < n; len++)
			for (int i = 0; i < n; i++) begin
				j = (i + len) % n;
				got = 0;
				best = 0;
				for (k = (i + 1) % n; k != j; k = (k + 1) % n) begin
					c = chord[i][j] + cost[i][k] + cost[k][j];
					if (!got || c < best) begin
						best = c;
						got = 1;
						split[i][j] = k;
					end
				end
				cost[i][j] = best;
			end
		have = 0;
		best = 0;
		bi = 0;
		bj = 0;
		for (int i = 0; i < n; i++)
			for (int jj = 0; jj < n; jj++) begin
				if (i == jj)
					continue;
				t = cost[i][jj] + cost[jj][i] - chord[i][jj];
				if (!have || t < best) begin
					best = t;
					bi = i;
					bj = jj;
					have = 1;
				end
			end
		if (!is_next(bj, bi, n) && !is_next(bi, bj, n)) begin
			add_diag(bi + 1, bj + 1, 1'b0);
			emitted++;
		end
		stk_a.push_back(bj); stk_b.push_back(bi); stk_e.push_back(0);
		stk_a.push_back(bi); stk_b.push_back(bj); stk_e.push_back(0);
		while (stk_a.size() > 0) begin
			a = stk_a.pop_back();
			b = stk_b.pop_back();
			k = stk_e.pop_back();
			if (a == b || is_next(a, b, n))
				continue;
			if (k != 0 && emitted < cpmt_pkg::MAX_DIAG) begin
				add_diag(a + 1, b + 1, 1'b0);
				emitted++;
			end
			k = split[a][b];
			stk_a.push_back(k); stk_b.push_back(b); stk_e.push_back(1);
			stk_a.push_back(a); stk_b.push_back(k); stk_e.push_back(1);
		end
		if (emitted > 0)
			expected_diags[$].last_result = 1'b1;
	endfunction

	function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
		if (vert_count < cpmt_pkg::MAX_VERTICES) begin
			vert_x[vert_count] = x;
			vert_y[vert_count] = y;
			vert_count++;
		end
		if (last)
			triangulate();
	endfunction

	function void check_diag(logic [5:0] a, logic [5:0] b, logic none, logic last);
		diag_t e;
		if (expected_diags.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected diagonal %0d-%0d none=%0b last=%0b", a, b, none, last);
			return;
		end
		e = expected_diags.pop_front();
		if (e.end_a !== a || e.end_b !== b || e.no_diagonal !== none ||
			e.last_result !== last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("diagonal mismatch: expected %0d-%0d none=%0b last=%0b, got %0d-%0d none=%0b last=%0b",
					e.end_a, e.end_b, e.no_diagonal, e.last_result, a, b, none, last);
		end
	endfunction
endclass

module testbench;
	localparam int STALL_LIMIT = 200000;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   diags_seen;
	int   quiet_cycles;
	int   hold_cycles;
	bit   hold_done;
	triangulation_scoreboard sb;

	cpmt_vtx_if  vtx();
	cpmt_diag_if diag();

	convex_polygon_min_triangulation dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx.sink),
		.diag   (diag.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Monitors and watchdog
	always @(posedge clk) begin
		if (vtx.valid && vtx.ready)
			sb.note_vertex(vtx.x_coord, vtx.y_coord, vtx.last_vertex);
		if (diag.valid && diag.ready) begin
			sb.check_diag(diag.end_a, diag.end_b, diag.no_diagonal, diag.last_result);
			diags_seen++;
		end
		if ((vtx.valid && vtx.ready) || (diag.valid && diag.ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stalls plus one long hold-off to back up the input
	always @(posedge clk) begin
		if (!arst_n)
			diag.ready <= 1'b0;
		else if (!hold_done && diags_seen >= 20 && hold_cycles < 400) begin
			hold_cycles <= hold_cycles + 1;
			if (hold_cycles == 399)
				hold_done <= 1'b1;
			diag.ready <= 1'b0;
		end else
			diag.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
		input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
		end
		vtx.valid <= 1'b1;
		vtx.x_coord <= x;
		vtx.y_coord <= y;
		vtx.last_vertex <= last;
		do
			@(posedge clk);
		while (!vtx.ready);
	endtask

	task automatic send_random_polygon(input int n);
		for (int i = 0; i < n; i++)
			send_vertex(16'($urandom), 16'($urandom), i == n - 1);
	endtask

	int sent;
	int n;

	initial begin
		sb = new();
		arst_n = 1'b0;
		vtx.valid = 1'b0;
		vtx.x_coord = '0;
		vtx.y_coord = '0;
		vtx.last_vertex = 1'b0;
		diag.ready = 1'b0;
		diags_seen = 0;
		quiet_cycles = 0;
		hold_cycles = 0;
		hold_done = 0;
		send_idle_pct = 14;
		recv_idle_pct = 49;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Too few vertices: one, two and three
		send_vertex(-16'sd32768, 16'sd32767, 1'b1);
		send_vertex(16'sd32767, -16'sd32768, 1'b0);
		send_vertex(16'sd0, 16'sd0, 1'b1);
		send_random_polygon(3);
		// Square at the coordinate extremes: all splits tie
		send_vertex(-16'sd32768, -16'sd32768, 1'b0);
		send_vertex(16'sd32767, -16'sd32768, 1'b0);
		send_vertex(16'sd32767, 16'sd32767, 1'b0);
		send_vertex(-16'sd32768, 16'sd32767, 1'b1);
		// Degenerate polygon: all vertices equal
		for (int i = 0; i < 5; i++)
			send_vertex(16'sd100, -16'sd100, i == 4);
		send_random_polygon(6);

		sent = 0;
		while (sent < 300) begin
			if (sent >= 200) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (sent >= 100) begin
				send_idle_pct = 49;
				recv_idle_pct = 14;
			end
			// mostly small polygons, a few near or beyond capacity
			if ($urandom_range(11) == 0)
				n = $urandom_range(36, 30);
			else
				n = $urandom_range(10, 1);
			send_random_polygon(n);
			sent += n;
		end
		vtx.valid <= 1'b0;
		// let the monitor note the final transfer before draining
		@(posedge clk);

		while (sb.expected_diags.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
rtl/cpmt_pkg.sv
rtl/cpmt_vtx_if.sv
rtl/cpmt_diag_if.sv
rtl/cpmt_dp.sv
rtl/cpmt_ctrl.sv
rtl/convex_polygon_min_triangulation.sv
dv/testbench.sv
